FILE: hw/rtl/bgedu_pkg.sv
// Shared types and constants for the battery gauge EMA/deadband unit.
// Register indexes, reset values and field widths. No dependencies.
package bgedu_pkg;

    localparam int MV_W    = 16;
    localparam int MA_W    = 16;
    localparam int ALPHA_W = 16;
    localparam int PCT_W   = 7;
    localparam int FILT_W  = 32;
    localparam int CFG_AW  = 3;
    localparam int CFG_DW  = 16;

    localparam logic [CFG_AW-1:0] REG_ALPHA     = 3'd0;
    localparam logic [CFG_AW-1:0] REG_EMPTY     = 3'd1;
    localparam logic [CFG_AW-1:0] REG_FULL      = 3'd2;
    localparam logic [CFG_AW-1:0] REG_DEADBAND  = 3'd3;
    localparam logic [CFG_AW-1:0] REG_THRESHOLD = 3'd4;

    localparam logic [ALPHA_W-1:0] ALPHA_RST     = 16'd6554;
    localparam logic [MV_W-1:0]    EMPTY_RST     = 16'd9000;
    localparam logic [MV_W-1:0]    FULL_RST      = 16'd12600;
    localparam logic [PCT_W-1:0]   DEADBAND_RST  = 7'd2;
    localparam logic [MA_W-1:0]    THRESHOLD_RST = 16'd100;

    localparam logic [PCT_W-1:0]   PCT_FULL      = 7'd100;

    typedef struct packed {
        logic [PCT_W-1:0] level_pct;
        logic             level_changed;
        logic             is_charging;
        logic             charging_changed;
    } gauge_out_t;

    typedef struct packed {
        logic start;
        logic done;
    } seq_ctl_t;

endpackage

FILE: hw/rtl/bgedu_ema.sv
// Bit-serial moving-average update: one multiplier bit of alpha and of
// (1 - alpha) per cycle, MSB first. Depends on bgedu_pkg.
module bgedu_ema (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [bgedu_pkg::ALPHA_W-1:0] alpha,
    input  logic [bgedu_pkg::MV_W-1:0]    sample_mv,
    input  logic [bgedu_pkg::FILT_W-1:0]  old_q16,
    output logic                          done,
    output logic [bgedu_pkg::FILT_W-1:0]  new_q16
);
    import bgedu_pkg::*;

    localparam int ACC_W = 48;
    localparam int MUL_W = ALPHA_W + 1;

    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [MUL_W-1:0]  m_reg, a_reg;
    logic [FILT_W-1:0] old_reg;
    logic [MV_W-1:0]   v_reg;
    logic [4:0]        cnt_reg;
    logic              busy_reg, done_reg;
    logic [ACC_W-1:0]  add_old, add_new;

    assign add_old  = m_reg[MUL_W-1] ? {16'd0, old_reg} : '0;
    assign add_new  = a_reg[MUL_W-1] ? {16'd0, v_reg, 16'd0} : '0;
    assign acc_next = {acc_reg[ACC_W-2:0], 1'b0} + add_old + add_new;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                if (old_q16 == '0) begin
                    done_reg <= 1'b1;
                end else begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= 5'(MUL_W - 1);
                end
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            old_reg <= old_q16;
            v_reg   <= sample_mv;
            a_reg   <= {1'b0, alpha};
            m_reg   <= 17'h10000 - {1'b0, alpha};
            if (old_q16 == '0) begin
                acc_reg <= {sample_mv, 32'd0};
            end else begin
                acc_reg <= '0;
            end
        end else if (busy_reg) begin
            acc_reg <= acc_next;
            a_reg   <= {a_reg[MUL_W-2:0], 1'b0};
            m_reg   <= {m_reg[MUL_W-2:0], 1'b0};
        end
    end

    assign done    = done_reg;
    assign new_q16 = acc_reg[47:16];

endmodule

FILE: hw/rtl/bgedu_div.sv
// Percent mapping: range checks, then a restoring divider that retires
// one quotient bit per cycle. Depends on bgedu_pkg.
module bgedu_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [bgedu_pkg::FILT_W-1:0] avg_q16,
    input  logic [bgedu_pkg::MV_W-1:0]   empty_mv,
    input  logic [bgedu_pkg::MV_W-1:0]   full_mv,
    output logic                         done,
    output logic [bgedu_pkg::PCT_W-1:0]  pct
);
    import bgedu_pkg::*;

    localparam int NUM_W = 23;
    localparam int DEN_W = MV_W + PCT_W - 1;
    localparam int PRD_W = FILT_W + 7;

    logic [FILT_W-1:0]  d_reg;
    logic [MV_W-1:0]    s_reg;
    logic               zero_reg, prep_reg, busy_reg, done_reg;
    logic [NUM_W-1:0]   rem_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [PCT_W-1:0]   q_reg;
    logic [2:0]         cnt_reg;
    logic [PRD_W-1:0]   prod;
    logic               ge;

    assign prod = {1'b0, d_reg[FILT_W-1:0], 6'd0} + {2'b0, d_reg[FILT_W-1:0], 5'd0}
                + {5'b0, d_reg[FILT_W-1:0], 2'd0};
    assign ge   = rem_reg >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prep_reg <= 1'b0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            prep_reg <= start;
            if (prep_reg) begin
                if (zero_reg || d_reg[FILT_W-1:16] >= s_reg) begin
                    done_reg <= 1'b1;
                end else begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= 3'(PCT_W - 1);
                end
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 3'd1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            d_reg    <= avg_q16 - {empty_mv, 16'd0};
            s_reg    <= full_mv - empty_mv;
            zero_reg <= (full_mv <= empty_mv) || (avg_q16 <= {empty_mv, 16'd0});
        end
        if (prep_reg) begin
            rem_reg <= prod[PRD_W-1:16];
            den_reg <= {s_reg, 6'd0};
            if (zero_reg) begin
                q_reg <= '0;
            end else if (d_reg[FILT_W-1:16] >= s_reg) begin
                q_reg <= PCT_FULL;
            end else begin
                q_reg <= '0;
            end
        end else if (busy_reg) begin
            if (ge) begin
                rem_reg <= rem_reg - {1'b0, den_reg};
            end
            q_reg   <= {q_reg[PCT_W-2:0], ge};
            den_reg <= {1'b0, den_reg[DEN_W-1:1]};
        end
    end

    assign done = done_reg;
    assign pct  = q_reg;

endmodule

FILE: hw/rtl/battery_gauge_ema_deadband_unit.sv
// Battery gauge top level: configuration registers, sequencer, deadband
// and charging logic. Depends on bgedu_pkg, bgedu_ema and bgedu_div.
//
// One sample word in, one result word out. A word passes from acceptance
// to result through the bit-serial average update (bypassed when the filter
// is unseeded) and the percent divider (one quotient bit per cycle, bypassed
// when the percent clamps). A new sample is taken the cycle after the
// previous result has moved into the output register, even while that
// result still waits there; a waiting result stalls the sequencer only
// when the next result is ready to load.
module battery_gauge_ema_deadband_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,   // voltage_mv, current_ma
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [15:0]                   m_tdata,   // level_pct, level_changed,
                                                     // is_charging, charging_changed
    input  logic                          cfg_we,
    input  logic [bgedu_pkg::CFG_AW-1:0]  cfg_addr,
    input  logic [bgedu_pkg::CFG_DW-1:0]  cfg_wdata
);
    import bgedu_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EMA  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [ALPHA_W-1:0]  alpha_reg;
    logic [MV_W-1:0]     empty_reg, full_reg;
    logic [PCT_W-1:0]    db_reg;
    logic signed [MA_W-1:0] thr_reg;

    logic [FILT_W-1:0]   filt_reg;
    logic [PCT_W-1:0]    level_reg, pct_reg;
    logic                chg_reg, chg_new_reg;
    logic                out_valid_reg;
    gauge_out_t          out_reg;

    seq_ctl_t            ema_ctl, div_ctl;
    logic [FILT_W-1:0]   ema_res;
    logic [PCT_W-1:0]    div_pct;
    logic                accept, out_free, load_out;
    logic [PCT_W-1:0]    diff;
    logic                lvl_upd;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign load_out = (state_reg == ST_OUT) && out_free;

    assign ema_ctl.start = accept;
    assign div_ctl.start = ema_ctl.done;

    bgedu_ema u_ema (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (ema_ctl.start),
        .alpha     (alpha_reg),
        .sample_mv (s_tdata[15:0]),
        .old_q16   (filt_reg),
        .done      (ema_ctl.done),
        .new_q16   (ema_res)
    );

    bgedu_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_ctl.start),
        .avg_q16  (ema_res),
        .empty_mv (empty_reg),
        .full_mv  (full_reg),
        .done     (div_ctl.done),
        .pct      (div_pct)
    );

    assign diff    = (pct_reg >= level_reg) ? pct_reg - level_reg : level_reg - pct_reg;
    assign lvl_upd = diff >= db_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept)       state_next = ST_EMA;
            ST_EMA:  if (ema_ctl.done) state_next = ST_DIV;
            ST_DIV:  if (div_ctl.done) state_next = ST_OUT;
            ST_OUT:  if (out_free)     state_next = ST_IDLE;
            default:                   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            alpha_reg     <= ALPHA_RST;
            empty_reg     <= EMPTY_RST;
            full_reg      <= FULL_RST;
            db_reg        <= DEADBAND_RST;
            thr_reg       <= THRESHOLD_RST;
            filt_reg      <= '0;
            level_reg     <= '0;
            chg_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                case (cfg_addr)
                    REG_ALPHA:     alpha_reg <= cfg_wdata;
                    REG_EMPTY:     empty_reg <= cfg_wdata;
                    REG_FULL:      full_reg  <= cfg_wdata;
                    REG_DEADBAND:  db_reg    <= cfg_wdata[PCT_W-1:0];
                    REG_THRESHOLD: thr_reg   <= cfg_wdata;
                    default: ;
                endcase
            end
            if (ema_ctl.done) begin
                filt_reg <= ema_res;
            end
            if (load_out) begin
                out_valid_reg <= 1'b1;
                chg_reg       <= chg_new_reg;
                if (lvl_upd) begin
                    level_reg <= pct_reg;
                end
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            chg_new_reg <= $signed(s_tdata[31:16]) > thr_reg;
        end
        if (div_ctl.done) begin
            pct_reg <= div_pct;
        end
        if (load_out) begin
            out_reg.level_pct        <= lvl_upd ? pct_reg : level_reg;
            out_reg.level_changed    <= lvl_upd;
            out_reg.is_charging      <= chg_new_reg;
            out_reg.charging_changed <= chg_new_reg != chg_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_reg.charging_changed, out_reg.is_charging,
                       out_reg.level_changed, out_reg.level_pct};

endmodule
